/* sv/button_accordion_midi_note_engine_macros.svh */
// ----------------------------------------------------------------------------
// Accordion note engine assertion macros
// Concurrent assertion shorthands used by the RTL file that checks
// itself.
// ----------------------------------------------------------------------------
`ifndef BUTTON_ACCORDION_MIDI_NOTE_ENGINE_MACROS_SVH
`define BUTTON_ACCORDION_MIDI_NOTE_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BACC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("accordion note engine: same-cycle check failed");

// next-cycle implication, disabled during reset
`define BACC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("accordion note engine: next-cycle check failed");

`endif

/* sv/bacc_pkg.sv */
// ----------------------------------------------------------------------------
// Accordion note engine package
// Word types, request and register codes, MIDI status codes and the note
// tables of the accordion note engine.
// ----------------------------------------------------------------------------
package bacc_pkg;

    localparam int NUM_BUTTONS = 12;

    // request codes
    localparam logic [3:0] REQ_BTN_DOWN    = 4'd0;
    localparam logic [3:0] REQ_BTN_UP      = 4'd1;
    localparam logic [3:0] REQ_BELLOWS_PULL = 4'd2;
    localparam logic [3:0] REQ_BELLOWS_REL = 4'd3;
    localparam logic [3:0] REQ_BASS_DOWN   = 4'd4;
    localparam logic [3:0] REQ_BASS_UP     = 4'd5;
    localparam logic [3:0] REQ_CHORD_DOWN  = 4'd6;
    localparam logic [3:0] REQ_CHORD_UP    = 4'd7;
    localparam logic [3:0] REQ_RELEASE_ALL = 4'd8;

    // register indexes
    localparam logic [1:0] CFG_KEY      = 2'd0;
    localparam logic [1:0] CFG_LAYOUT   = 2'd1;
    localparam logic [1:0] CFG_REVERSE  = 2'd2;
    localparam logic [1:0] CFG_VELOCITY = 2'd3;

    // MIDI status bytes
    localparam logic [7:0] ST_MEL_ON    = 8'h90;
    localparam logic [7:0] ST_MEL_OFF   = 8'h80;
    localparam logic [7:0] ST_BASS_ON   = 8'h91;
    localparam logic [7:0] ST_BASS_OFF  = 8'h81;
    localparam logic [7:0] ST_CHORD_ON  = 8'h92;
    localparam logic [7:0] ST_CHORD_OFF = 8'h82;

    localparam logic [2:0] KEY_LAST = 3'd6;

    typedef struct packed {
        logic [3:0] req_type;
        logic [3:0] key_position;
    } in_word_t;

    typedef struct packed {
        logic [7:0] midi_status;
        logic [6:0] note_number;
        logic [6:0] note_velocity;
        logic       last_of_run;
    } out_word_t;

    // which message slots an event fills
    typedef struct packed {
        logic                   bass_off;
        logic                   bass_on;
        logic                   chord_off;
        logic                   chord_on;
        logic                   mel_off;
        logic                   mel_on;
        logic                   dir_off;
        logic                   dir_on;
        logic [NUM_BUTTONS-1:0] mask;
    } job_t;

    function automatic logic signed [3:0] key_shift(input logic [2:0] k);
        logic signed [3:0] s;
        unique case (k)
            3'd0:    s = 4'sd3;
            3'd1:    s = -4'sd2;
            3'd2:    s = 4'sd5;
            3'd3:    s = 4'sd0;
            3'd4:    s = -4'sd5;
            3'd5:    s = 4'sd2;
            default: s = -4'sd3;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] melody_base(input logic layout, input logic [3:0] btn,
                                               input logic dir);
        logic [6:0] n;
        unique case (btn)
            4'd0:    n = dir ? 7'd53 : 7'd48;
            4'd1:    n = dir ? (layout ? 7'd55 : 7'd57) : 7'd52;
            4'd2:    n = dir ? 7'd59 : 7'd55;
            4'd3:    n = dir ? 7'd62 : 7'd60;
            4'd4:    n = dir ? 7'd65 : 7'd64;
            4'd5:    n = dir ? 7'd69 : 7'd67;
            4'd6:    n = dir ? 7'd71 : 7'd72;
            4'd7:    n = dir ? 7'd74 : 7'd76;
            4'd8:    n = dir ? 7'd77 : 7'd79;
            4'd9:    n = dir ? 7'd81 : 7'd84;
            4'd10:   n = dir ? 7'd83 : 7'd88;
            4'd11:   n = dir ? 7'd86 : 7'd91;
            default: n = 7'd0;
        endcase
        return n;
    endfunction

    function automatic logic [6:0] bass_note(input logic [2:0] k, input logic dir);
        logic [6:0] n;
        unique case (k)
            3'd0:    n = dir ? 7'd46 : 7'd39;
            3'd1:    n = dir ? 7'd41 : 7'd46;
            3'd2:    n = dir ? 7'd36 : 7'd41;
            3'd3:    n = dir ? 7'd43 : 7'd36;
            3'd4:    n = dir ? 7'd38 : 7'd43;
            3'd5:    n = dir ? 7'd45 : 7'd38;
            default: n = dir ? 7'd40 : 7'd45;
        endcase
        return n;
    endfunction

    function automatic logic [6:0] chord_note(input logic [2:0] k, input logic upper,
                                              input logic dir);
        logic [6:0] n;
        unique case (k)
            3'd0:    n = upper ? (dir ? 7'd65 : 7'd70) : (dir ? 7'd70 : 7'd63);
            3'd1:    n = upper ? (dir ? 7'd60 : 7'd65) : (dir ? 7'd65 : 7'd70);
            3'd2:    n = upper ? (dir ? 7'd67 : 7'd60) : (dir ? 7'd60 : 7'd65);
            3'd3:    n = upper ? (dir ? 7'd62 : 7'd67) : (dir ? 7'd67 : 7'd60);
            3'd4:    n = upper ? (dir ? 7'd69 : 7'd62) : (dir ? 7'd62 : 7'd67);
            3'd5:    n = upper ? (dir ? 7'd64 : 7'd69) : (dir ? 7'd69 : 7'd62);
            default: n = upper ? (dir ? 7'd71 : 7'd64) : (dir ? 7'd64 : 7'd69);
        endcase
        return n;
    endfunction

endpackage

/* sv/button_accordion_midi_note_engine.sv */
// ----------------------------------------------------------------------------
// Button accordion MIDI note engine
// Turns button, bellows, bass and chord events into MIDI note-on and
// note-off words, keeping the held state of the instrument.
// ----------------------------------------------------------------------------
// Each accepted event stalls the input until its run ends, so no new event
// is taken before the last is through. After the accept cycle a sequencer
// walks 30 message slots, one per cycle unless output stalls hold it (bass
// off, bass on, two chord offs, two chord ons, then an off and an on slot
// for each of the 12 melody buttons from button 0 upward), through a single
// note lookup and transposition unit, and closes with a flush step. Words
// pass through a one-word holding stage so that the final word of an event
// can be marked with last_of_run; an event that causes nothing gives no word.
`include "button_accordion_midi_note_engine_macros.svh"

module button_accordion_midi_note_engine
    import bacc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word,
    input  logic      cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    localparam logic [4:0] PH_BASS_OFF   = 5'd0;
    localparam logic [4:0] PH_BASS_ON    = 5'd1;
    localparam logic [4:0] PH_CHORD0_OFF = 5'd2;
    localparam logic [4:0] PH_CHORD1_OFF = 5'd3;
    localparam logic [4:0] PH_CHORD0_ON  = 5'd4;
    localparam logic [4:0] PH_CHORD1_ON  = 5'd5;
    localparam logic [4:0] PH_MEL_BASE   = 5'd6;
    localparam logic [4:0] PH_FLUSH      = 5'd30;

    logic [2:0] key_reg;
    logic       layout_reg;
    logic       reverse_reg;
    logic [6:0] velocity_reg;

    logic                   state_reg, state_next;
    logic [4:0]             phase_reg, phase_next;
    job_t                   job_reg, job_next;
    out_word_t              pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    out_word_t              out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [NUM_BUTTONS-1:0] held_reg, held_next;
    logic                   bellows_reg, bellows_next;
    logic                   bass_reg, bass_next;
    logic                   chord_reg, chord_next;

    logic              accept;
    logic              out_free;
    logic [2:0]        cur_key;
    logic signed [3:0] shift4;
    logic [6:0]        shift7;
    logic [4:0]        mel_idx;
    logic [3:0]        btn_sel;
    logic              gen;
    out_word_t         msg;
    logic [3:0]        map_btn;
    logic [NUM_BUTTONS-1:0] map_bit;
    logic              pos_ok;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign cur_key = (key_reg > KEY_LAST) ? KEY_LAST : key_reg;
    assign shift4  = key_shift(cur_key);
    assign shift7  = {{3{shift4[3]}}, shift4};
    assign mel_idx = phase_reg - PH_MEL_BASE;
    assign btn_sel = mel_idx[4:1];

    // shared note unit: one slot per cycle unless output stalls hold the sequencer
    always_comb
    begin
        gen = 1'b0;
        msg = '0;
        unique case (phase_reg)
            PH_BASS_OFF:
            begin
                gen = job_reg.bass_off;
                msg.midi_status = ST_BASS_OFF;
                msg.note_number = bass_note(cur_key, job_reg.dir_off);
            end
            PH_BASS_ON:
            begin
                gen = job_reg.bass_on;
                msg.midi_status   = ST_BASS_ON;
                msg.note_number   = bass_note(cur_key, job_reg.dir_on);
                msg.note_velocity = velocity_reg;
            end
            PH_CHORD0_OFF, PH_CHORD1_OFF:
            begin
                gen = job_reg.chord_off;
                msg.midi_status = ST_CHORD_OFF;
                msg.note_number = chord_note(cur_key, phase_reg == PH_CHORD1_OFF,
                                             job_reg.dir_off);
            end
            PH_CHORD0_ON, PH_CHORD1_ON:
            begin
                gen = job_reg.chord_on;
                msg.midi_status   = ST_CHORD_ON;
                msg.note_number   = chord_note(cur_key, phase_reg == PH_CHORD1_ON,
                                               job_reg.dir_on);
                msg.note_velocity = velocity_reg;
            end
            default:
            begin
                if (phase_reg < PH_FLUSH)
                begin
                    if (mel_idx[0])
                    begin
                        gen = job_reg.mask[btn_sel] && job_reg.mel_on;
                        msg.midi_status   = ST_MEL_ON;
                        msg.note_number   = melody_base(layout_reg, btn_sel, job_reg.dir_on)
                                            + shift7;
                        msg.note_velocity = velocity_reg;
                    end
                    else
                    begin
                        gen = job_reg.mask[btn_sel] && job_reg.mel_off;
                        msg.midi_status = ST_MEL_OFF;
                        msg.note_number = melody_base(layout_reg, btn_sel, job_reg.dir_off)
                                          + shift7;
                    end
                end
            end
        endcase
    end

    assign pos_ok  = (in_word.key_position < 4'(NUM_BUTTONS));
    assign map_btn = reverse_reg ? in_word.key_position
                                 : 4'(NUM_BUTTONS - 1) - in_word.key_position;
    assign map_bit = NUM_BUTTONS'(1) << map_btn;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        job_next        = job_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        held_next       = held_reg;
        bellows_next    = bellows_reg;
        bass_next       = bass_reg;
        chord_next      = chord_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next      = ST_SCAN;
                    phase_next      = PH_BASS_OFF;
                    pend_valid_next = 1'b0;
                    job_next        = '0;
                    job_next.dir_off = bellows_reg;
                    job_next.dir_on  = bellows_reg;
                    unique case (in_word.req_type)
                        REQ_BTN_DOWN:
                        begin
                            if (pos_ok && !(|(held_reg & map_bit)))
                            begin
                                held_next       = held_reg | map_bit;
                                job_next.mask   = map_bit;
                                job_next.mel_on = 1'b1;
                            end
                        end
                        REQ_BTN_UP:
                        begin
                            if (pos_ok && (|(held_reg & map_bit)))
                            begin
                                held_next        = held_reg & ~map_bit;
                                job_next.mask    = map_bit;
                                job_next.mel_off = 1'b1;
                            end
                        end
                        REQ_BELLOWS_PULL, REQ_BELLOWS_REL:
                        begin
                            // flip: stop everything held, restart at the new direction
                            if (bellows_reg != (in_word.req_type == REQ_BELLOWS_PULL))
                            begin
                                bellows_next       = !bellows_reg;
                                job_next.dir_off   = bellows_reg;
                                job_next.dir_on    = !bellows_reg;
                                job_next.bass_off  = bass_reg;
                                job_next.bass_on   = bass_reg;
                                job_next.chord_off = chord_reg;
                                job_next.chord_on  = chord_reg;
                                job_next.mel_off   = 1'b1;
                                job_next.mel_on    = 1'b1;
                                job_next.mask      = held_reg;
                            end
                        end
                        REQ_BASS_DOWN:
                        begin
                            bass_next        = 1'b1;
                            job_next.bass_on = !bass_reg;
                        end
                        REQ_BASS_UP:
                        begin
                            bass_next         = 1'b0;
                            job_next.bass_off = bass_reg;
                        end
                        REQ_CHORD_DOWN:
                        begin
                            chord_next        = 1'b1;
                            job_next.chord_on = !chord_reg;
                        end
                        REQ_CHORD_UP:
                        begin
                            chord_next         = 1'b0;
                            job_next.chord_off = chord_reg;
                        end
                        REQ_RELEASE_ALL:
                        begin
                            job_next.bass_off  = bass_reg;
                            job_next.chord_off = chord_reg;
                            job_next.mel_off   = 1'b1;
                            job_next.mask      = held_reg;
                            held_next          = '0;
                            bass_next          = 1'b0;
                            chord_next         = 1'b0;
                            bellows_next       = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (phase_reg == PH_FLUSH)
                begin
                    // release the held word marked as last
                    if (!pend_valid_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_next             = pend_reg;
                        out_next.last_of_run = 1'b1;
                        out_valid_next       = 1'b1;
                        pend_valid_next      = 1'b0;
                        state_next           = ST_IDLE;
                    end
                end
                else if (gen)
                begin
                    if (!pend_valid_reg)
                    begin
                        pend_next       = msg;
                        pend_valid_next = 1'b1;
                        phase_next      = phase_reg + 5'd1;
                    end
                    else if (out_free)
                    begin
                        out_next             = pend_reg;
                        out_next.last_of_run = 1'b0;
                        out_valid_next       = 1'b1;
                        pend_next            = msg;
                        phase_next           = phase_reg + 5'd1;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg        <= 3'd3;
            layout_reg     <= 1'b1;
            reverse_reg    <= 1'b0;
            velocity_reg   <= 7'd127;
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_BASS_OFF;
            job_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_reg       <= '0;
            bellows_reg    <= 1'b0;
            bass_reg       <= 1'b0;
            chord_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_KEY:      key_reg      <= cfg_data[2:0];
                    CFG_LAYOUT:   layout_reg   <= cfg_data[0];
                    CFG_REVERSE:  reverse_reg  <= cfg_data[0];
                    CFG_VELOCITY: velocity_reg <= cfg_data;
                    default:      key_reg      <= key_reg;
                endcase
            end
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            job_reg        <= job_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            held_reg       <= held_next;
            bellows_reg    <= bellows_next;
            bass_reg       <= bass_next;
            chord_reg      <= chord_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    `BACC_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, accept,
                      state_reg == ST_SCAN && phase_reg == PH_BASS_OFF)
    `BACC_ASSERT_NOW(a_phase_in_range, clk, rst_n, 1'b1, phase_reg <= PH_FLUSH)
    `BACC_ASSERT_NEXT(a_held_stable_in_scan, clk, rst_n, state_reg == ST_SCAN,
                      $stable(held_reg))
    `BACC_ASSERT_NEXT(a_flush_marks_last, clk, rst_n,
                      state_reg == ST_SCAN && phase_reg == PH_FLUSH && pend_valid_reg
                      && out_free,
                      out_valid_reg && out_reg.last_of_run)

endmodule

/* tb/tb_button_accordion_midi_note_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Accordion note engine testbench
// Drives button, bellows, bass, chord and release-all events through the note engine
// under random sender gaps and receiver stalls. Every word that comes out
// is compared against an in-bench prediction of the note messages, across
// a sweep of key, layout, order and velocity settings.
// ----------------------------------------------------------------------------
module tb_button_accordion_midi_note_engine;
    import bacc_pkg::*;

    localparam int         HOLD_CYCLES = 400;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         SETTLE_CYCLES = 64;
    localparam int         RANDOM_EVENTS = 200;
    localparam logic [3:0] REQ_CODE_MAX = 4'hF;

    // pitch tables: [layout][button][pull], [key][pull], [key][upper][pull]
    localparam int MELODY_TAB [2][12][2] = '{
        '{'{48, 53}, '{52, 57}, '{55, 59}, '{60, 62}, '{64, 65}, '{67, 69},
          '{72, 71}, '{76, 74}, '{79, 77}, '{84, 81}, '{88, 83}, '{91, 86}},
        '{'{48, 53}, '{52, 55}, '{55, 59}, '{60, 62}, '{64, 65}, '{67, 69},
          '{72, 71}, '{76, 74}, '{79, 77}, '{84, 81}, '{88, 83}, '{91, 86}}};
    localparam int BASS_TAB [7][2] = '{
        '{39, 46}, '{46, 41}, '{41, 36}, '{36, 43}, '{43, 38}, '{38, 45}, '{45, 40}};
    localparam int CHORD_TAB [7][2][2] = '{
        '{'{63, 70}, '{70, 65}}, '{'{70, 65}, '{65, 60}}, '{'{65, 60}, '{60, 67}},
        '{'{60, 67}, '{67, 62}}, '{'{67, 62}, '{62, 69}}, '{'{62, 69}, '{69, 64}},
        '{'{69, 64}, '{64, 71}}};
    localparam int KEY_OFFSET [7] = '{3, -2, 5, 0, -5, 2, -3};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_word;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_word;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    // predicted instrument state and register copies
    logic [NUM_BUTTONS-1:0] held_buttons;
    logic                   bellows_out;
    logic                   bass_down;
    logic                   chord_down;
    logic [2:0]             sel_key;
    logic                   sel_layout;
    logic                   sel_reverse;
    logic [6:0]             sel_velocity;

    out_word_t expected_notes [$];
    int        errors;
    int        counted_events;
    int        quiet_cycles;

    // sender and receiver pacing
    logic send_idle_en;
    logic recv_idle_en;
    int   burst_left;
    int   recv_run;
    logic hold_req;
    int   hold_count;

    button_accordion_midi_note_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int eff_key();
        return (sel_key > KEY_LAST) ? int'(KEY_LAST) : int'(sel_key);
    endfunction

    function automatic logic [6:0] melody_pitch(input int btn, input logic dir);
        return 7'(MELODY_TAB[sel_layout][btn][dir] + KEY_OFFSET[eff_key()]);
    endfunction

    function automatic void note_word(input logic [7:0] status, input int note,
                                      input logic on);
        out_word_t w;
        w.midi_status   = status;
        w.note_number   = 7'(note);
        w.note_velocity = on ? sel_velocity : 7'd0;
        w.last_of_run   = 1'b0;
        expected_notes.push_back(w);
    endfunction

    function automatic void chord_words(input logic dir, input logic on);
        note_word(on ? ST_CHORD_ON : ST_CHORD_OFF, CHORD_TAB[eff_key()][0][dir], on);
        note_word(on ? ST_CHORD_ON : ST_CHORD_OFF, CHORD_TAB[eff_key()][1][dir], on);
    endfunction

    // stop every sounding note at the old pitch and restart it at the new
    function automatic void flip_bellows_to(input logic dir);
        logic prev;
        prev = ~dir;
        bellows_out = dir;
        if (bass_down)
        begin
            note_word(ST_BASS_OFF, BASS_TAB[eff_key()][prev], 1'b0);
            note_word(ST_BASS_ON, BASS_TAB[eff_key()][dir], 1'b1);
        end
        if (chord_down)
        begin
            chord_words(prev, 1'b0);
            chord_words(dir, 1'b1);
        end
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (held_buttons[i])
            begin
                note_word(ST_MEL_OFF, melody_pitch(i, prev), 1'b0);
                note_word(ST_MEL_ON, melody_pitch(i, dir), 1'b1);
            end
        end
    endfunction

    function automatic void predict_notes(input in_word_t w);
        int first;
        int btn;
        first = expected_notes.size();
        case (w.req_type)
            REQ_BTN_DOWN, REQ_BTN_UP:
            begin
                if (w.key_position < NUM_BUTTONS)
                begin
                    btn = sel_reverse ? int'(w.key_position)
                                      : NUM_BUTTONS - 1 - int'(w.key_position);
                    if (w.req_type == REQ_BTN_DOWN && !held_buttons[btn])
                    begin
                        held_buttons[btn] = 1'b1;
                        note_word(ST_MEL_ON, melody_pitch(btn, bellows_out), 1'b1);
                    end
                    else if (w.req_type == REQ_BTN_UP && held_buttons[btn])
                    begin
                        held_buttons[btn] = 1'b0;
                        note_word(ST_MEL_OFF, melody_pitch(btn, bellows_out), 1'b0);
                    end
                end
            end
            REQ_BELLOWS_PULL:
                if (!bellows_out)
                    flip_bellows_to(1'b1);
            REQ_BELLOWS_REL:
                if (bellows_out)
                    flip_bellows_to(1'b0);
            REQ_BASS_DOWN:
                if (!bass_down)
                begin
                    bass_down = 1'b1;
                    note_word(ST_BASS_ON, BASS_TAB[eff_key()][bellows_out], 1'b1);
                end
            REQ_BASS_UP:
                if (bass_down)
                begin
                    bass_down = 1'b0;
                    note_word(ST_BASS_OFF, BASS_TAB[eff_key()][bellows_out], 1'b0);
                end
            REQ_CHORD_DOWN:
                if (!chord_down)
                begin
                    chord_down = 1'b1;
                    chord_words(bellows_out, 1'b1);
                end
            REQ_CHORD_UP:
                if (chord_down)
                begin
                    chord_down = 1'b0;
                    chord_words(bellows_out, 1'b0);
                end
            REQ_RELEASE_ALL:
            begin
                if (bass_down)
                begin
                    bass_down = 1'b0;
                    note_word(ST_BASS_OFF, BASS_TAB[eff_key()][bellows_out], 1'b0);
                end
                if (chord_down)
                begin
                    chord_down = 1'b0;
                    chord_words(bellows_out, 1'b0);
                end
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    if (held_buttons[i])
                    begin
                        held_buttons[i] = 1'b0;
                        note_word(ST_MEL_OFF, melody_pitch(i, bellows_out), 1'b0);
                    end
                end
                bellows_out = 1'b0;
            end
            default: ;
        endcase
        if (expected_notes.size() > first)
            expected_notes[expected_notes.size() - 1].last_of_run = 1'b1;
    endfunction

    // offer one event word, hold it until taken, then predict its notes
    task automatic send_event(input logic [3:0] req, input logic [3:0] pos);
        in_word_t w;
        int       gap;
        w.req_type     = req;
        w.key_position = pos;
        gap = 0;
        if (send_idle_en && burst_left == 0)
        begin
            gap        = $urandom_range(1, 70);
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0)
            burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_notes(w);
        if (req <= REQ_RELEASE_ALL && (req > REQ_BTN_UP || pos < NUM_BUTTONS))
            counted_events++;
    endtask

    // drop valid, drain every expected word, then let the sequencer finish
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [2:0] key, input logic layout,
                                input logic rev, input logic [6:0] vel);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_KEY;
        cfg_data  <= {4'($urandom), key};
        @(posedge clk);
        cfg_index <= CFG_LAYOUT;
        cfg_data  <= {6'($urandom), layout};
        @(posedge clk);
        cfg_index <= CFG_REVERSE;
        cfg_data  <= {6'($urandom), rev};
        @(posedge clk);
        cfg_index <= CFG_VELOCITY;
        cfg_data  <= vel;
        @(posedge clk);
        cfg_write    <= 1'b0;
        sel_key      = key;
        sel_layout   = layout;
        sel_reverse  = rev;
        sel_velocity = vel;
    endtask

    function automatic logic [6:0] pick_velocity();
        case ($urandom_range(0, 3))
            0:       return 7'd0;
            1:       return 7'd127;
            default: return 7'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b1;
        send_event(REQ_BTN_DOWN, 4'd0);
        send_event(REQ_BTN_DOWN, 4'd11);
        send_event(REQ_BTN_DOWN, 4'd5);
        send_event(REQ_BTN_DOWN, 4'd0);
        send_event(REQ_BTN_DOWN, 4'd12);
        send_event(REQ_BTN_UP, 4'd15);
        send_event(REQ_BASS_DOWN, 4'd0);
        send_event(REQ_BASS_DOWN, 4'd0);
        send_event(REQ_CHORD_DOWN, 4'd0);
        send_event(REQ_BELLOWS_PULL, 4'd0);
        send_event(REQ_BELLOWS_PULL, 4'd0);
        send_event(REQ_BTN_UP, 4'd11);
        send_event(REQ_BTN_UP, 4'd11);
        send_event(REQ_BELLOWS_REL, 4'd0);
        send_event(REQ_BELLOWS_REL, 4'd0);
        send_event(REQ_BASS_UP, 4'd0);
        send_event(REQ_CHORD_UP, 4'd0);
        send_event(REQ_CHORD_UP, 4'd0);
        send_event(REQ_RELEASE_ALL + 4'd1, 4'd3);
        send_event(REQ_CODE_MAX, 4'd15);
        send_event(REQ_BASS_DOWN, 4'd0);
        send_event(REQ_CHORD_DOWN, 4'd0);
        send_event(REQ_BELLOWS_PULL, 4'd0);
        send_event(REQ_RELEASE_ALL, 4'd0);
        send_event(REQ_RELEASE_ALL, 4'd0);
    endtask

    // every key including the out-of-range one; notes stay held across
    // each change so the next release-all sounds off with the new settings
    task automatic test_register_sweep();
        logic [3:0] k;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        for (k = 0; k < 8; k++)
        begin
            program_regs(k[2:0], k[0], k[1],
                         (k == 0) ? 7'd0 : (k == 7) ? 7'd127 : 7'($urandom));
            send_event(REQ_RELEASE_ALL, 4'($urandom));
            send_event(REQ_BTN_DOWN, 4'($urandom_range(0, NUM_BUTTONS - 1)));
            send_event(REQ_BTN_DOWN, 4'($urandom_range(0, NUM_BUTTONS - 1)));
            send_event(REQ_BASS_DOWN, 4'($urandom));
            send_event(REQ_BELLOWS_PULL, 4'($urandom));
            send_event(REQ_CHORD_DOWN, 4'($urandom));
            send_event(REQ_BELLOWS_REL, 4'($urandom));
        end
    endtask

    // fill every slot, then hold the output so full flips back up the block
    task automatic test_backpressure();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        send_event(REQ_RELEASE_ALL, 4'd0);
        for (int p = 0; p < NUM_BUTTONS; p++)
            send_event(REQ_BTN_DOWN, 4'(p));
        send_event(REQ_BASS_DOWN, 4'd0);
        send_event(REQ_CHORD_DOWN, 4'd0);
        hold_req <= 1'b1;
        for (int n = 0; n < 5; n++)
        begin
            send_event(REQ_BELLOWS_PULL, 4'd0);
            send_event(REQ_BELLOWS_REL, 4'd0);
        end
        send_event(REQ_RELEASE_ALL, 4'd0);
        settle();
        hold_req <= 1'b0;
    endtask

    task automatic test_random_play();
        int r;
        counted_events = 0;
        while (counted_events < RANDOM_EVENTS)
        begin
            if (counted_events % 50 == 0)
            begin
                program_regs(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
                             pick_velocity());
                send_idle_en = 1'($urandom);
                recv_idle_en = 1'($urandom);
            end
            r = $urandom_range(0, 99);
            if (r < 30)
                send_event(REQ_BTN_DOWN, 4'($urandom_range(0, NUM_BUTTONS - 1)));
            else if (r < 50)
                send_event(REQ_BTN_UP, 4'($urandom_range(0, NUM_BUTTONS - 1)));
            else if (r < 58)
                send_event(REQ_BELLOWS_PULL, 4'($urandom));
            else if (r < 66)
                send_event(REQ_BELLOWS_REL, 4'($urandom));
            else if (r < 72)
                send_event(REQ_BASS_DOWN, 4'($urandom));
            else if (r < 77)
                send_event(REQ_BASS_UP, 4'($urandom));
            else if (r < 83)
                send_event(REQ_CHORD_DOWN, 4'($urandom));
            else if (r < 88)
                send_event(REQ_CHORD_UP, 4'($urandom));
            else if (r < 91)
                send_event(REQ_RELEASE_ALL, 4'($urandom));
            else if (r < 95)
                send_event(4'($urandom_range(REQ_RELEASE_ALL + 1, REQ_CODE_MAX)),
                           4'($urandom));
            else
                send_event(4'($urandom_range(REQ_BTN_DOWN, REQ_BTN_UP)),
                           4'($urandom_range(NUM_BUTTONS, 15)));
        end
    endtask

    initial
    begin
        errors       = 0;
        burst_left   = 0;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        held_buttons = '0;
        bellows_out  = 1'b0;
        bass_down    = 1'b0;
        chord_down   = 1'b0;
        sel_key      = 3'd3;
        sel_layout   = 1'b1;
        sel_reverse  = 1'b0;
        sel_velocity = 7'd127;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_KEY;
        cfg_data  <= '0;
        hold_req  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_sweep();
        test_backpressure();
        test_random_play();
        settle();

        if (errors == 0 && expected_notes.size() == 0)
            $display("tb_button_accordion_midi_note_engine: done, clean");
        else
            $display("tb_button_accordion_midi_note_engine: done, errors");
        $finish;
    end

    // receiver: long hold on request, otherwise alternating stall and free runs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            recv_run   <= 0;
            hold_count <= 0;
        end
        else if (hold_req && hold_count < HOLD_CYCLES)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            if (!hold_req)
                hold_count <= 0;
            if (!recv_idle_en)
            begin
                out_stall <= 1'b0;
                recv_run  <= 0;
            end
            else if (recv_run > 0)
                recv_run <= recv_run - 1;
            else
            begin
                out_stall <= ~out_stall;
                recv_run  <= out_stall ? $urandom_range(0, 9) : $urandom_range(0, 3);
            end
        end
    end

    always @(posedge clk)
    begin : check_words
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_notes.size() == 0)
            begin
                $display("%0t: word with none expected: %h", $time, out_word);
                errors++;
            end
            else
            begin
                want = expected_notes.pop_front();
                if (out_word.midi_status !== want.midi_status)
                begin
                    $display("%0t: midi_status expected %h got %h",
                             $time, want.midi_status, out_word.midi_status);
                    errors++;
                end
                if (out_word.note_number !== want.note_number)
                begin
                    $display("%0t: note_number expected %0d got %0d",
                             $time, want.note_number, out_word.note_number);
                    errors++;
                end
                if (out_word.note_velocity !== want.note_velocity)
                begin
                    $display("%0t: note_velocity expected %0d got %0d",
                             $time, want.note_velocity, out_word.note_velocity);
                    errors++;
                end
                if (out_word.last_of_run !== want.last_of_run)
                begin
                    $display("%0t: last_of_run expected %b got %b",
                             $time, want.last_of_run, out_word.last_of_run);
                    errors++;
                end
            end
        end
    end

    // abandon the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_button_accordion_midi_note_engine: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial quiet_cycles = 0;

endmodule

/* filelist.f */
+incdir+sv
sv/bacc_pkg.sv
sv/button_accordion_midi_note_engine.sv
tb/tb_button_accordion_midi_note_engine.sv
